@@ sv/iatv_pkg.sv @@
// Package for the IP address text validator: codes, character values and limits.
package iatv_pkg;

  // Length limits of a well-formed address string
  localparam int unsigned MAX_LEN      = 39;
  localparam int unsigned MIN_LEN      = 7;
  // Kind is fixed only by a separator among the first characters
  localparam int unsigned KIND_WINDOW  = 5;
  localparam int unsigned OCTET_MAX    = 255;
  localparam int unsigned V4_DOTS      = 3;
  localparam int unsigned V6_COLONS    = 7;
  localparam int unsigned V6_GROUP_MAX = 4;

  // Saturation tops of the counters
  localparam logic [5:0] CNT_TOP    = 6'd63;
  localparam logic [8:0] OCTET_TOP  = 9'd511;
  localparam logic [1:0] DIGIT_TOP  = 2'd3;
  localparam logic [2:0] DOT_TOP    = 3'd7;
  localparam logic [2:0] GROUP_TOP  = 3'd7;
  localparam logic [3:0] COLON_TOP  = 4'd15;

  // ASCII values
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_F    = 8'h46;

  // Address kind, fixed by the first separator
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_V4   = 2'd1,
    KIND_V6   = 2'd2
  } kind_t;

  // Result codes
  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_V4   = 2'd1,
    VERDICT_V6   = 2'd2
  } verdict_t;

endpackage

@@ sv/ip_address_text_validator.sv @@
// Top level of the IP address text validator: input register, checkers, result register.
// The block takes one character per cycle, with in_is_last marking the end of the string,
// and gives one verdict per string (0 neither, 1 valid IPv4, 2 valid IPv6) on the result
// channel. A character can be taken every cycle while verdicts are taken as they come.
// The last character's verdict is formed as it leaves the input register and is written
// to the result register once that register is free; it can then be taken. While a
// verdict waits on the result channel the input register holds its character, so at most
// one more character is taken until the verdict goes. The IPv4 and IPv6 checkers update
// their counters in a single pass of logic between those two registers. After the last
// character all checker state returns to its reset value, so the next string may follow
// at once. Strings longer than STR_MAX_LEN characters (39 by default), without a separator
// among their first five characters, or with any malformed field give verdict 0.
module ip_address_text_validator
  import iatv_pkg::*;
#(
  parameter int unsigned STR_MAX_LEN = MAX_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_character,
  input  logic       in_is_last,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [1:0] out_verdict,
  output logic       out_valid,
  input  logic       out_ready
);

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // Result register
  logic       out_valid_r;
  verdict_t   out_verdict_r;

  // Checker state
  logic [5:0] char_count_r,   char_count_nxt;
  kind_t      addr_kind_r,    addr_kind_nxt;
  logic [8:0] octet_value_r,  octet_value_nxt;
  logic [1:0] octet_digits_r, octet_digits_nxt;
  logic [2:0] dot_count_r,    dot_count_nxt;
  logic [2:0] group_len_r,    group_len_nxt;
  logic [3:0] colon_count_r,  colon_count_nxt;
  logic       v4_bad_r,       v4_bad_nxt;
  logic       v6_bad_r,       v6_bad_nxt;

  logic       out_free;
  logic       step;
  logic       is_dec;
  logic       is_hex;
  logic [3:0] digit;
  logic [12:0] octet_mul;
  logic       len_ok;
  verdict_t   verdict;

  // Handshake: the result register frees when empty or taken
  assign out_free    = !out_valid_r || out_ready;
  assign step        = s1_valid_r && out_free;
  assign in_ready    = !s1_valid_r || out_free;
  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  // Character classes
  assign is_dec = (s1_char_r >= CH_0) && (s1_char_r <= CH_9);
  assign is_hex = is_dec
               || ((s1_char_r >= CH_LC_A) && (s1_char_r <= CH_LC_F))
               || ((s1_char_r >= CH_UC_A) && (s1_char_r <= CH_UC_F));
  assign digit  = s1_char_r[3:0] - CH_0[3:0];
  // value * 10 + digit, as shifts and adds
  assign octet_mul = {1'b0, octet_value_r, 3'b000} + {3'b000, octet_value_r, 1'b0}
                   + {9'd0, digit};

  // Checker state update for the character in the input register
  always_comb begin
    char_count_nxt   = char_count_r;
    addr_kind_nxt    = addr_kind_r;
    octet_value_nxt  = octet_value_r;
    octet_digits_nxt = octet_digits_r;
    dot_count_nxt    = dot_count_r;
    group_len_nxt    = group_len_r;
    colon_count_nxt  = colon_count_r;
    v4_bad_nxt       = v4_bad_r;
    v6_bad_nxt       = v6_bad_r;

    // kind from the first separator within the window
    if (addr_kind_r == KIND_NONE && char_count_r < 6'(KIND_WINDOW)) begin
      if (s1_char_r == CH_DOT) begin
        addr_kind_nxt = KIND_V4;
      end else if (s1_char_r == CH_COLON) begin
        addr_kind_nxt = KIND_V6;
      end
    end
    if (char_count_r != CNT_TOP) begin
      char_count_nxt = char_count_r + 6'd1;
    end

    // IPv4 checker
    if (is_dec) begin
      if (octet_digits_r != 2'd0 && octet_value_r == 9'd0) begin
        v4_bad_nxt = 1'b1;
      end
      octet_value_nxt = (octet_mul > {4'd0, OCTET_TOP}) ? OCTET_TOP : octet_mul[8:0];
      if (octet_value_nxt > 9'(OCTET_MAX)) begin
        v4_bad_nxt = 1'b1;
      end
      if (octet_digits_r != DIGIT_TOP) begin
        octet_digits_nxt = octet_digits_r + 2'd1;
      end
    end else if (s1_char_r == CH_DOT) begin
      if (octet_digits_r == 2'd0) begin
        v4_bad_nxt = 1'b1;
      end
      if (dot_count_r != DOT_TOP) begin
        dot_count_nxt = dot_count_r + 3'd1;
      end
      octet_value_nxt  = 9'd0;
      octet_digits_nxt = 2'd0;
    end else begin
      v4_bad_nxt = 1'b1;
    end

    // IPv6 checker
    if (is_hex) begin
      if (group_len_r != GROUP_TOP) begin
        group_len_nxt = group_len_r + 3'd1;
      end
      if (group_len_nxt > 3'(V6_GROUP_MAX)) begin
        v6_bad_nxt = 1'b1;
      end
    end else if (s1_char_r == CH_COLON) begin
      if (group_len_r == 3'd0) begin
        v6_bad_nxt = 1'b1;
      end
      if (colon_count_r != COLON_TOP) begin
        colon_count_nxt = colon_count_r + 4'd1;
      end
      group_len_nxt = 3'd0;
    end else begin
      v6_bad_nxt = 1'b1;
    end
  end

  // Verdict from the updated state
  always_comb begin
    len_ok = (char_count_nxt >= 6'(MIN_LEN)) && (char_count_nxt <= 6'(STR_MAX_LEN));
    if (len_ok && addr_kind_nxt == KIND_V4 && !v4_bad_nxt
        && dot_count_nxt == 3'(V4_DOTS) && octet_digits_nxt != 2'd0) begin
      verdict = VERDICT_V4;
    end else if (len_ok && addr_kind_nxt == KIND_V6 && !v6_bad_nxt
        && colon_count_nxt == 4'(V6_COLONS) && group_len_nxt != 3'd0) begin
      verdict = VERDICT_V6;
    end else begin
      verdict = VERDICT_NONE;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_character;
      s1_last_r <= in_is_last;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (step && s1_last_r) begin
      out_verdict_r <= verdict;
    end
  end

  // Control and checker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      char_count_r   <= '0;
      addr_kind_r    <= KIND_NONE;
      octet_value_r  <= '0;
      octet_digits_r <= '0;
      dot_count_r    <= '0;
      group_len_r    <= '0;
      colon_count_r  <= '0;
      v4_bad_r       <= 1'b0;
      v6_bad_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (step && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (step) begin
        if (s1_last_r) begin
          // end of string: back to reset state
          char_count_r   <= '0;
          addr_kind_r    <= KIND_NONE;
          octet_value_r  <= '0;
          octet_digits_r <= '0;
          dot_count_r    <= '0;
          group_len_r    <= '0;
          colon_count_r  <= '0;
          v4_bad_r       <= 1'b0;
          v6_bad_r       <= 1'b0;
        end else begin
          char_count_r   <= char_count_nxt;
          addr_kind_r    <= addr_kind_nxt;
          octet_value_r  <= octet_value_nxt;
          octet_digits_r <= octet_digits_nxt;
          dot_count_r    <= dot_count_nxt;
          group_len_r    <= group_len_nxt;
          colon_count_r  <= colon_count_nxt;
          v4_bad_r       <= v4_bad_nxt;
          v6_bad_r       <= v6_bad_nxt;
        end
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the IP address text validator: directed and random strings, self-checking.
`timescale 1ns / 1ps

module tb;
  import iatv_pkg::*;

  typedef logic [7:0] text_t[$];

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned MAX_REPORTS    = 10;

  logic       clk;
  logic       rst_n;
  logic [7:0] in_character;
  logic       in_is_last;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] out_verdict;
  logic       out_valid;
  logic       out_ready;

  ip_address_text_validator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_character (in_character),
    .in_is_last   (in_is_last),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_verdict  (out_verdict),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  // Predicted checker state
  logic [5:0] len_cnt;
  kind_t      addr_kind;
  logic [8:0] octet_val;
  logic [1:0] octet_digits;
  logic [2:0] dots_seen;
  logic [2:0] group_digits;
  logic [3:0] colons_seen;
  bit         v4_failed;
  bit         v6_failed;

  verdict_t   pending_verdicts[$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned chars_sent;
  int unsigned strings_sent;
  int unsigned mismatches;
  int unsigned seen_v4;
  int unsigned seen_v6;
  int unsigned seen_none;
  int unsigned quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_checker_state();
    len_cnt      = '0;
    addr_kind    = KIND_NONE;
    octet_val    = '0;
    octet_digits = '0;
    dots_seen    = '0;
    group_digits = '0;
    colons_seen  = '0;
    v4_failed    = 1'b0;
    v6_failed    = 1'b0;
  endfunction

  // Advance the predicted state by one character; queue a verdict on the last one
  function automatic void predict_char(input logic [7:0] ch, input logic last);
    bit          is_dec;
    bit          is_hex;
    bit          len_ok;
    int unsigned nv;
    verdict_t    v;
    is_dec = (ch >= CH_0) && (ch <= CH_9);
    is_hex = is_dec || ((ch >= CH_LC_A) && (ch <= CH_LC_F)) ||
             ((ch >= CH_UC_A) && (ch <= CH_UC_F));

    if (addr_kind == KIND_NONE && len_cnt < KIND_WINDOW) begin
      if (ch == CH_DOT) addr_kind = KIND_V4;
      else if (ch == CH_COLON) addr_kind = KIND_V6;
    end
    if (len_cnt != CNT_TOP) len_cnt = len_cnt + 6'd1;

    // dotted decimal side
    if (is_dec) begin
      if (octet_digits != 0 && octet_val == 0) v4_failed = 1'b1;
      nv = int'(octet_val) * 10 + int'(ch) - int'(CH_0);
      octet_val = (nv > int'(OCTET_TOP)) ? OCTET_TOP : nv[8:0];
      if (octet_val > OCTET_MAX) v4_failed = 1'b1;
      if (octet_digits != DIGIT_TOP) octet_digits = octet_digits + 2'd1;
    end else if (ch == CH_DOT) begin
      if (octet_digits == 0) v4_failed = 1'b1;
      if (dots_seen != DOT_TOP) dots_seen = dots_seen + 3'd1;
      octet_val    = '0;
      octet_digits = '0;
    end else begin
      v4_failed = 1'b1;
    end

    // colon hex side
    if (is_hex) begin
      if (group_digits != GROUP_TOP) group_digits = group_digits + 3'd1;
      if (group_digits > V6_GROUP_MAX) v6_failed = 1'b1;
    end else if (ch == CH_COLON) begin
      if (group_digits == 0) v6_failed = 1'b1;
      if (colons_seen != COLON_TOP) colons_seen = colons_seen + 4'd1;
      group_digits = '0;
    end else begin
      v6_failed = 1'b1;
    end

    if (last) begin
      len_ok = (len_cnt >= MIN_LEN) && (len_cnt <= MAX_LEN);
      v = VERDICT_NONE;
      if (len_ok && addr_kind == KIND_V4 && !v4_failed && dots_seen == V4_DOTS &&
          octet_digits != 0)
        v = VERDICT_V4;
      else if (len_ok && addr_kind == KIND_V6 && !v6_failed &&
               colons_seen == V6_COLONS && group_digits != 0)
        v = VERDICT_V6;
      pending_verdicts.push_back(v);
      clear_checker_state();
    end
  endfunction

  function automatic text_t to_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // Character mix weighted towards what the checkers care about
  function automatic logic [7:0] pick_char();
    string       hexdig;
    int unsigned r;
    hexdig = "0123456789abcdefABCDEF";
    r = $urandom_range(99);
    if (r < 40) return CH_0 + 8'($urandom_range(9));
    if (r < 55) return hexdig[$urandom_range(21)];
    if (r < 70) return CH_DOT;
    if (r < 85) return CH_COLON;
    return 8'($urandom_range(255));
  endfunction

  function automatic string make_ipv4();
    string       s;
    int unsigned r;
    int unsigned octet;
    s = "";
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(2);
      octet = (r == 0) ? $urandom_range(9) :
              (r == 1) ? $urandom_range(99, 10) : $urandom_range(255, 100);
      s = (i == 0) ? $sformatf("%0d", octet) : $sformatf("%s.%0d", s, octet);
    end
    return s;
  endfunction

  function automatic string make_ipv6();
    string hexdig;
    string s;
    int    glen;
    hexdig = "0123456789abcdefABCDEF";
    s = "";
    for (int i = 0; i < 8; i++) begin
      if (i != 0) s = {s, ":"};
      glen = $urandom_range(4, 1);
      for (int j = 0; j < glen; j++) s = {s, string'(hexdig[$urandom_range(21)])};
    end
    return s;
  endfunction

  // Small random damage: replace, drop, insert or append one character
  function automatic void damage(ref text_t t);
    int unsigned pos;
    pos = $urandom_range(t.size() - 1);
    case ($urandom_range(3))
      0: t[pos] = pick_char();
      1: if (t.size() > 1) t.delete(pos);
      2: t.insert(pos, pick_char());
      default: t.push_back(pick_char());
    endcase
  endfunction

  // Send one character; prediction is taken at the transfer edge
  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    in_is_last   <= last;
    do @(posedge clk); while (!in_ready);
    predict_char(ch, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input text_t t);
    for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
    strings_sent++;
  endtask

  task automatic send_str(input string s);
    send_text(to_text(s));
  endtask

  // Hold the input off until every verdict has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  // Dotted decimal rules: octet range, leading zeros, dot count, empty fields
  task automatic test_ipv4_rules();
    send_str("0.0.0.0");
    send_str("255.255.255.255");
    send_str("256.1.1.1");
    send_str("01.2.3.4");
    send_str("00.0.0.0");
    send_str("10.20.30.");
    send_str("1..22.33");
    send_str("1.2.3.4.5");
    send_str("9999.1.1.1");
    send_str("1.2.3.4a");
    send_str("1.1.1.1.1.1.1.1.1");
  endtask

  // Colon hex rules: group size, colon count, case of hex letters, stray characters
  task automatic test_ipv6_rules();
    send_str("ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff");
    send_str("0:1:2:3:4:5:6:7");
    send_str("A:b:C:d:E:f:09:FfFf");
    send_str("12345:1:1:1:1:1:1:1");
    send_str("1:2:3:4:5:6:7:");
    send_str("1::2:3:4:5:6:7");
    send_str("1:2:3:4:5:6:7:8:9");
    send_str("g:1:2:3:4:5:6:7");
    send_str("12345678:1:2:3:4:5:6");
    send_str("1:2.3.4.5");
  endtask

  // Length bounds, kind window, NUL and top-bit bytes, counter saturation
  task automatic test_length_and_kind();
    text_t t;
    string s;
    send_str("1");
    send_str("1.2.3");
    send_str("123456.1.1.1");
    send_str("abcdef:1:2:3:4:5:6");
    send_str("0ffff:ffff:ffff:ffff:ffff:ffff:ffff:fff");
    t = to_text("1.2.3.4");
    t.push_back(8'h00);
    send_text(t);
    t = to_text("1:2:3:4:5:6:7:8");
    t.insert(3, 8'hFF);
    send_text(t);
    s = "";
    for (int i = 0; i < 35; i++) s = {s, "1:"};
    send_str(s);
    s = "";
    for (int i = 0; i < 33; i++) s = {s, "9."};
    send_str(s);
    drain_results();
  endtask

  // Random strings, mostly well formed, the rest damaged or noise
  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned n_chars);
    text_t       t;
    int unsigned r;
    int unsigned start;
    bit          paused;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start  = chars_sent;
    paused = 1'b0;
    while (chars_sent - start < n_chars) begin
      r = $urandom_range(99);
      if (r < 30) begin
        t = to_text(make_ipv4());
      end else if (r < 60) begin
        t = to_text(make_ipv6());
      end else if (r < 85) begin
        t = to_text(($urandom_range(1) != 0) ? make_ipv4() : make_ipv6());
        repeat ($urandom_range(3, 1)) damage(t);
      end else begin
        t.delete();
        repeat ($urandom_range(45, 1)) t.push_back(pick_char());
      end
      send_text(t);
      if (!paused && chars_sent - start >= n_chars / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected verdict %0d", out_verdict));
      end else begin
        verdict_t want;
        want = pending_verdicts.pop_front();
        case (want)
          VERDICT_V4: seen_v4++;
          VERDICT_V6: seen_v6++;
          default:    seen_none++;
        endcase
        if (out_verdict !== want)
          report_mismatch($sformatf("verdict expected %0d (%s), got %0d",
                                    want, want.name(), out_verdict));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_character = '0;
    in_is_last   = 1'b0;
    out_ready    = 1'b0;
    src_idle_pct = 32;
    snk_idle_pct = 58;
    chars_sent   = 0;
    strings_sent = 0;
    mismatches   = 0;
    seen_v4      = 0;
    seen_v6      = 0;
    seen_none    = 0;
    quiet_cycles = 0;
    clear_checker_state();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_ipv4_rules();
    test_ipv6_rules();
    test_length_and_kind();
    test_random_traffic(32, 58, 130);
    test_random_traffic(58, 32, 130);
    test_random_traffic(0, 0, 130);
    finish_run();

    $display("tb: %0d strings in %0d characters under three idling patterns",
             strings_sent, chars_sent);
    $display("tb: verdicts checked: %0d IPv4, %0d IPv6, %0d rejected, %0d mismatches",
             seen_v4, seen_v6, seen_none, mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
